// ----- rtl/core/sfr_pkg.sv -----
`default_nettype none
package sfr_pkg;

   localparam int PORT_COUNT    = 4;
   localparam int PAYLOAD_BYTES = 128;
   localparam int PORT_W        = 2;
   localparam int IDX_W         = 7;
   localparam int POS_W         = 8;
   localparam int RAM_DEPTH     = PORT_COUNT * PAYLOAD_BYTES;
   localparam int RAM_AW        = $clog2(RAM_DEPTH);
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [1:0] OP_RX    = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] PH_HUNT1 = 2'd0;
   localparam logic [1:0] PH_HUNT2 = 2'd1;
   localparam logic [1:0] PH_BODY  = 2'd2;

   localparam logic [2:0] ST_NONE   = 3'd0;
   localparam logic [2:0] ST_OK     = 3'd1;
   localparam logic [2:0] ST_CSUM   = 3'd2;
   localparam logic [2:0] ST_TYPE   = 3'd3;
   localparam logic [2:0] ST_DIR    = 3'd4;
   localparam logic [2:0] ST_LENGTH = 3'd5;

   localparam logic [0:0] CSR_HDR1 = 1'd0;
   localparam logic [0:0] CSR_HDR2 = 1'd1;

   localparam logic [POS_W-1:0] CSUM_POS = POS_W'(4 + PAYLOAD_BYTES);
   localparam logic [31:0] FRAME_BYTES = 32'(PAYLOAD_BYTES + 7);
   localparam logic [31:0] PPM_SCALE   = 32'd1000000;

   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] port;
      logic [7:0] rx_byte;
      logic [6:0] payload_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  frame_id;
      logic [7:0]  frame_type;
      logic        direction;
      logic [7:0]  checksum_value;
      logic [7:0]  payload_byte;
      logic [31:0] rx_byte_cnt;
      logic [31:0] good_frame_cnt;
      logic [31:0] bad_frame_cnt;
      logic [31:0] bad_byte_cnt;
      logic [31:0] drop_byte_cnt;
      logic [19:0] err_ppm;
   } rsp_type;

   // classified command passed front to back
   typedef struct packed {
      logic              valid_port;
      logic [1:0]        opcode;
      logic [PORT_W-1:0] port;
      logic [7:0]        rx_byte;
      logic [6:0]        payload_index;
   } cmd_type;

endpackage
`default_nettype wire

// ----- rtl/core/sfr_ram.sv -----
`default_nettype none
module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/sfr_front.sv -----
`default_nettype none
module sfr_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   output logic                 full,
   input  wire sfr_pkg::req_type req_data,
   output logic                 cmd_valid,
   output sfr_pkg::cmd_type     cmd_data,
   input  wire logic            cmd_take
);
   import sfr_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(QUEUE_DEPTH);

   cmd_type         q_ff [QUEUE_DEPTH];
   logic [AW-1:0]   rd_ff, rd_in, wr_ff, wr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   cmd_type         cls;
   logic            do_push, do_pop;

   always_comb begin
      cls.valid_port    = (32'(req_data.port) < PORT_COUNT);
      cls.opcode        = req_data.opcode;
      cls.port          = req_data.port;
      cls.rx_byte       = req_data.rx_byte;
      cls.payload_index = req_data.payload_index;
   end

   assign full      = (cnt_ff == CW'(QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      rd_in  = do_pop ? AW'((32'(rd_ff) + 1) % QUEUE_DEPTH) : rd_ff;
      wr_in  = do_push ? AW'((32'(wr_ff) + 1) % QUEUE_DEPTH) : wr_ff;
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ff] <= cls;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/sfr_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle; 52-bit dividend by 32-bit divisor
module sfr_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [51:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             busy,
   output logic [19:0]      ppm
);
   import sfr_pkg::*;

   logic [51:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;
   logic [32:0] diff;

   assign trial = {rem_ff, quo_ff[51]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = 6'd52;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits 32 bits
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[50:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[50:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign ppm  = (quo_ff > 52'(PPM_SCALE)) ? 20'(PPM_SCALE) : quo_ff[19:0];
endmodule
`default_nettype wire

// ----- rtl/core/sfr_back.sv -----
`default_nettype none
module sfr_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire sfr_pkg::cmd_type cmd_data,
   output logic                  cmd_take,
   input  wire logic [7:0]       hdr1,
   input  wire logic [7:0]       hdr2,
   output logic                  rsp_valid,
   output sfr_pkg::rsp_type      rsp_data,
   input  wire logic             rsp_take
);
   import sfr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_COPY = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;
   localparam logic [2:0] S_DSTART = 3'd5;

   localparam int PAYW = $clog2(PAYLOAD_BYTES + 1);

   logic [2:0]  state_ff, state_in;
   cmd_type     cur_ff, cur_in;
   rsp_type     res_ff, res_in;
   logic        out_ff, out_in;

   logic [1:0]       phase_ff [PORT_COUNT];
   logic [POS_W-1:0] pos_ff   [PORT_COUNT];
   logic [7:0]       sum_ff   [PORT_COUNT];
   logic [31:0]      fld_ff   [PORT_COUNT];
   logic [31:0]      byt_ff   [PORT_COUNT];
   logic [31:0]      good_ff  [PORT_COUNT];
   logic [31:0]      badf_ff  [PORT_COUNT];
   logic [31:0]      badb_ff  [PORT_COUNT];
   logic [31:0]      drop_ff  [PORT_COUNT];
   logic [19:0]      rate_ff  [PORT_COUNT];

   logic [PAYW-1:0]  cp_ff, cp_in;
   logic             recalc;
   logic [RAM_AW-1:0] cp_base;

   // receive and delivered stores
   logic              rx_we, dl_we;
   logic [RAM_AW-1:0] rx_wa, rx_ra, dl_wa, dl_ra;
   logic [7:0]        rx_wd, rx_rd, dl_rd;

   logic        div_start, div_busy;
   logic [19:0] div_ppm;
   logic [51:0] div_num;

   logic [PORT_W-1:0] p;
   logic [7:0]        b;
   logic [1:0]        ph;
   logic [POS_W-1:0]  pos;
   logic [7:0]        fty, fdir, flen;
   logic [2:0]        st;
   logic              upd;
   logic [31:0]       byt_n, good_n, badf_n, badb_n, drop_n;
   logic [1:0]        ph_n;
   logic [POS_W-1:0]  pos_n;
   logic [7:0]        sum_n;
   logic [31:0]       fld_n;
   logic              copy_n;

   assign p    = cur_ff.port;
   assign b    = cur_ff.rx_byte;
   assign ph   = phase_ff[p];
   assign pos  = pos_ff[p];
   assign fty  = fld_ff[p][15:8];
   assign fdir = fld_ff[p][23:16];
   assign flen = fld_ff[p][31:24];

   // per-item update, evaluated in the cycle after capture (state S_RD)
   assign upd = state_ff == S_RD && cur_ff.valid_port;

   // receive-store write happens in S_RD alongside the update
   assign cp_base = RAM_AW'(32'(p) * PAYLOAD_BYTES);
   assign rx_we   = upd && cur_ff.opcode == OP_RX && ph == PH_BODY
                    && pos >= POS_W'(4) && pos < CSUM_POS;
   assign rx_wa   = cp_base + RAM_AW'(pos - POS_W'(4));
   assign rx_wd   = b;
   assign rx_ra   = cp_base + RAM_AW'(cp_ff);
   assign dl_we   = state_ff == S_COPY && cp_ff != '0;
   assign dl_wa   = cp_base + RAM_AW'(cp_ff - PAYW'(1));
   assign dl_ra   = cp_base + RAM_AW'(cur_ff.payload_index);

   sfr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_rx_ram (
      .clock(clock), .wr_en(rx_we), .wr_addr(rx_wa), .wr_data(rx_wd),
      .rd_addr(rx_ra), .rd_data(rx_rd)
   );
   sfr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_dl_ram (
      .clock(clock), .wr_en(dl_we), .wr_addr(dl_wa), .wr_data(rx_rd),
      .rd_addr(dl_ra), .rd_data(dl_rd)
   );

   assign div_num = 52'(badb_ff[p]) * 52'(PPM_SCALE);
   assign div_start = state_ff == S_DSTART && byt_ff[p] != '0;

   sfr_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(byt_ff[p]), .busy(div_busy), .ppm(div_ppm)
   );

   assign cmd_take  = state_ff == S_IDLE && !out_ff && cmd_valid;

   always_comb begin
      byt_n  = byt_ff[p];
      good_n = good_ff[p];
      badf_n = badf_ff[p];
      badb_n = badb_ff[p];
      drop_n = drop_ff[p];
      ph_n   = ph;
      pos_n  = pos;
      sum_n  = sum_ff[p];
      fld_n  = fld_ff[p];
      copy_n = 1'b0;
      recalc = 1'b0;
      st     = ST_NONE;
      if (cur_ff.opcode == OP_CLEAR) begin
         byt_n = '0; good_n = '0; badf_n = '0; badb_n = '0; drop_n = '0;
         ph_n = PH_HUNT1; pos_n = '0; sum_n = '0;
      end else if (cur_ff.opcode == OP_RX) begin
         byt_n = byt_ff[p] + 32'd1;
         case (ph)
            PH_HUNT1: begin
               if (b == hdr1) begin
                  ph_n = PH_HUNT2;
               end else begin
                  drop_n = drop_n + 32'd1; badb_n = badb_n + 32'd1; recalc = 1'b1;
               end
            end
            PH_HUNT2: begin
               if (b == hdr2) begin
                  ph_n = PH_BODY; pos_n = '0; sum_n = '0;
               end else begin
                  drop_n = drop_n + 32'd1; badb_n = badb_n + 32'd1; recalc = 1'b1;
                  if (b == hdr1) begin
                     ph_n = PH_HUNT2;
                  end else begin
                     ph_n = PH_HUNT1; pos_n = '0; sum_n = '0;
                  end
               end
            end
            PH_BODY: begin
               if (pos < CSUM_POS) begin
                  sum_n = sum_ff[p] + b;
                  case (pos)
                     POS_W'(0): fld_n[7:0]   = b;
                     POS_W'(1): fld_n[15:8]  = b;
                     POS_W'(2): fld_n[23:16] = b;
                     POS_W'(3): fld_n[31:24] = b;
                     default: fld_n = fld_ff[p];
                  endcase
                  pos_n = pos + POS_W'(1);
               end else begin
                  if (sum_ff[p] != b) begin
                     st = ST_CSUM;
                  end else if (!(fty == 8'h00 || fty == 8'hFF || fty == 8'h55
                                 || fty == 8'hAA)) begin
                     st = ST_TYPE;
                  end else if (fdir > 8'd1) begin
                     st = ST_DIR;
                  end else if (32'(flen) != PAYLOAD_BYTES) begin
                     st = ST_LENGTH;
                  end else begin
                     st = ST_OK;
                  end
                  if (st == ST_OK) begin
                     good_n = good_n + 32'd1; copy_n = 1'b1;
                  end else begin
                     badf_n = badf_n + 32'd1; badb_n = badb_n + FRAME_BYTES;
                  end
                  recalc = 1'b1;
                  ph_n = PH_HUNT1; pos_n = '0; sum_n = '0;
               end
            end
            default: begin
               ph_n = PH_HUNT1; pos_n = '0; sum_n = '0;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      res_in   = res_ff;
      out_in   = out_ff;
      cp_in    = cp_ff;
      case (state_ff)
         S_IDLE: begin
            if (out_ff && rsp_take) begin
               out_in = 1'b0;
            end
            if (cmd_take) begin
               cur_in   = cmd_data;
               state_in = S_RD;
            end
         end
         S_RD: begin
            res_in = '0;
            if (cur_ff.valid_port) begin
               res_in.status = st;
               if (st == ST_OK) begin
                  res_in.frame_id       = fld_ff[p][7:0];
                  res_in.frame_type     = fty;
                  res_in.direction      = fdir[0];
                  res_in.checksum_value = b;
               end
               res_in.rx_byte_cnt    = byt_n;
               res_in.good_frame_cnt = good_n;
               res_in.bad_frame_cnt  = badf_n;
               res_in.bad_byte_cnt   = badb_n;
               res_in.drop_byte_cnt  = drop_n;
               res_in.err_ppm        = cur_ff.opcode == OP_CLEAR ? '0 : rate_ff[p];
            end
            cp_in = '0;
            if (!cur_ff.valid_port) begin
               state_in = S_OUT;
            end else if (copy_n) begin
               state_in = S_COPY;
            end else if (recalc) begin
               state_in = S_DSTART;
            end else if (cur_ff.opcode == OP_READ) begin
               state_in = S_OUT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_COPY: begin
            cp_in = cp_ff + PAYW'(1);
            if (cp_ff == PAYW'(PAYLOAD_BYTES)) begin
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            if (byt_ff[p] == '0) begin
               res_in.err_ppm = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               res_in.err_ppm = div_ppm;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (cur_ff.valid_port && cur_ff.opcode == OP_READ
                && 32'(cur_ff.payload_index) < PAYLOAD_BYTES) begin
               res_in.payload_byte = dl_rd;
            end
            out_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff   <= 1'b0;
         cur_ff   <= '0;
         for (int i = 0; i < PORT_COUNT; i++) begin
            phase_ff[i] <= PH_HUNT1;
            pos_ff[i]   <= '0;
            sum_ff[i]   <= '0;
            byt_ff[i]   <= '0;
            good_ff[i]  <= '0;
            badf_ff[i]  <= '0;
            badb_ff[i]  <= '0;
            drop_ff[i]  <= '0;
            rate_ff[i]  <= '0;
         end
      end else begin
         state_ff  <= state_in;
         out_ff    <= out_in;
         cur_ff    <= cur_in;
         if (upd) begin
            phase_ff[p] <= ph_n;
            pos_ff[p]   <= pos_n;
            sum_ff[p]   <= sum_n;
            byt_ff[p]   <= byt_n;
            good_ff[p]  <= good_n;
            badf_ff[p]  <= badf_n;
            badb_ff[p]  <= badb_n;
            drop_ff[p]  <= drop_n;
            if (cur_ff.opcode == OP_CLEAR) begin
               rate_ff[p] <= '0;
            end
         end
         if (state_ff == S_DSTART && byt_ff[p] == '0) begin
            rate_ff[p] <= '0;
         end
         if (state_ff == S_DIV && !div_busy) begin
            rate_ff[p] <= div_ppm;
         end
      end
      if (upd) begin
         fld_ff[p] <= fld_n;
      end
      cp_ff  <= cp_in;
      res_ff <= res_in;
   end

   assign rsp_valid = out_ff;
   assign rsp_data  = res_ff;
endmodule
`default_nettype wire

// ----- rtl/core/serial_frame_receiver_with_stats.sv -----
// Serial frame receiver with per-port statistics.
// Input channel: req_data beat (opcode, port, rx_byte, payload_index) is taken
//   when push is high and full is low. A two-entry command queue sits behind
//   the request port, so requests are taken while a result waits.
// Result channel: rsp_data is valid while empty is low; pop takes the beat.
//   Exactly one result beat per request beat, in order.
// Config: csr_wr_en/csr_index/csr_data write header bytes (index 0 first,
//   index 1 second); write only while idle.
// Path: a plain beat passes through states S_RD and S_OUT into the result
//   register. A byte that ends a frame or drops sync recomputes the ppm rate
//   through a 52-bit bit-serial divider (states S_DSTART, S_DIV). A good frame
//   first copies the payload into the delivered store (state S_COPY).
// Flow: one beat in the back end at a time; the next beat is taken only once
//   the result is popped, and the divider and copy set the pace on frame-end bytes.
// Reset: parsers hunt the first header, counters and rates clear, queue
//   empties; payload stores keep contents (unwritten entries undefined).
// Stall: if pop is held low the result register holds; the back end waits,
//   the queue fills and full rises.
`default_nettype none
module serial_frame_receiver_with_stats (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire sfr_pkg::req_type req_data,
   output logic                  empty,
   input  wire logic             pop,
   output sfr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_index,
   input  wire logic [7:0]       csr_data
);
   import sfr_pkg::*;

   logic [7:0] hdr1_q_ff, hdr2_q_ff;
   logic       cmd_valid, cmd_take, rsp_valid;
   cmd_type    cmd_data;

   // header byte registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr1_q_ff <= 8'hEB;
         hdr2_q_ff <= 8'h90;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HDR1: hdr1_q_ff <= csr_data;
            CSR_HDR2: hdr2_q_ff <= csr_data;
            default: ;
         endcase
      end
   end

   sfr_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_data(req_data), .cmd_valid(cmd_valid), .cmd_data(cmd_data),
      .cmd_take(cmd_take)
   );

   sfr_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_data(cmd_data),
      .cmd_take(cmd_take), .hdr1(hdr1_q_ff), .hdr2(hdr2_q_ff),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_take(pop)
   );

   assign empty = !rsp_valid;
endmodule
`default_nettype wire

// ----- rtl/core/sfr_check.sv -----
`default_nettype none
module sfr_check (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             push,
   input wire logic             full,
   input wire logic             empty,
   input wire logic             pop,
   input wire sfr_pkg::rsp_type rsp_data
);
   import sfr_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      empty == 1'b0 && !pop |=> !empty && $stable(rsp_data))
      else $error("result changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_data.status <= ST_LENGTH)
      else $error("bad status code");
   a_ppm: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_data.err_ppm <= 20'(PPM_SCALE))
      else $error("ppm out of range");
   a_fields: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.status != ST_OK |-> rsp_data.frame_id == 8'd0
      && rsp_data.checksum_value == 8'd0)
      else $error("frame fields set without good frame");
   a_reset: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("not empty after reset");
endmodule

bind serial_frame_receiver_with_stats sfr_check u_check (
   .clock(clock), .reset(reset), .push(push), .full(full), .empty(empty),
   .pop(pop), .rsp_data(rsp_data)
);
`default_nettype wire

// ----- tb/tb_serial_frame_receiver_with_stats.sv -----
`default_nettype none
module tb_serial_frame_receiver_with_stats;
   import sfr_pkg::*;

   // Cycles without any beat on either side before the run is given up.
   // A good frame end and the long receiver hold are both far shorter,
   // so this leaves a wide margin.
   localparam int STALL_LIMIT  = 5000;
   localparam int TARGET_ITEMS = 1150;
   localparam int HOLD_CYCLES  = 300;
   localparam int FRAME_LEN    = PAYLOAD_BYTES + 7;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_index;
   logic [7:0] csr_data;

   serial_frame_receiver_with_stats i_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------
   // Frame parser model: per-port parse state, counters and payload stores
   // ------------------------------------------------------------------
   logic [7:0]  hdr_first;
   logic [7:0]  hdr_second;
   logic [1:0]  phase     [PORT_COUNT];
   logic [7:0]  body_pos  [PORT_COUNT];
   logic [7:0]  body_sum  [PORT_COUNT];
   logic [31:0] hdr_fields[PORT_COUNT];
   logic [7:0]  rx_store  [PORT_COUNT][PAYLOAD_BYTES];
   logic [7:0]  dl_store  [PORT_COUNT][PAYLOAD_BYTES];
   bit          has_good  [PORT_COUNT];
   logic [31:0] n_bytes   [PORT_COUNT];
   logic [31:0] n_good    [PORT_COUNT];
   logic [31:0] n_badf    [PORT_COUNT];
   logic [31:0] n_badb    [PORT_COUNT];
   logic [31:0] n_drop    [PORT_COUNT];
   logic [19:0] ppm       [PORT_COUNT];

   rsp_type expected_q[$];
   int      fails;
   int      items_sent;
   bit      quiet;         // no idling on either side while set
   int      hold_seq;      // bumped by the sender to request a long pop hold

   function automatic logic [19:0] error_ppm(logic [31:0] bad, logic [31:0] total);
      logic [63:0] q;
      if (total == 0) return '0;
      q = ({32'd0, bad} * 64'd1000000) / {32'd0, total};
      if (q > 64'd1000000) return 20'd1000000;  // saturate on double counting
      return q[19:0];
   endfunction

   function automatic void count_drop(int p);
      n_drop[p]++;
      n_badb[p]++;
      ppm[p] = error_ppm(n_badb[p], n_bytes[p]);
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type    o;
      int         p;
      logic [7:0] b;
      logic [7:0] ty;
      logic [7:0] dir;
      logic [7:0] len;
      o = '0;
      p = r.port;
      b = r.rx_byte;
      case (r.opcode)
         OP_RX: begin
            n_bytes[p]++;
            case (phase[p])
               PH_HUNT1: begin
                  if (b == hdr_first) phase[p] = PH_HUNT2;
                  else count_drop(p);
               end
               PH_HUNT2: begin
                  if (b == hdr_second) begin
                     phase[p]    = PH_BODY;
                     body_pos[p] = '0;
                     body_sum[p] = '0;
                  end else begin
                     count_drop(p);
                     // a repeated first header byte keeps hunting the second
                     phase[p] = (b == hdr_first) ? PH_HUNT2 : PH_HUNT1;
                  end
               end
               PH_BODY: begin
                  if (body_pos[p] < CSUM_POS) begin
                     body_sum[p] += b;
                     if (body_pos[p] < 4) hdr_fields[p][body_pos[p]*8 +: 8] = b;
                     else rx_store[p][body_pos[p]-4] = b;
                     body_pos[p]++;
                  end else begin
                     ty  = hdr_fields[p][15:8];
                     dir = hdr_fields[p][23:16];
                     len = hdr_fields[p][31:24];
                     // checks in priority order
                     if (body_sum[p] != b) o.status = ST_CSUM;
                     else if (!(ty inside {8'h00, 8'hFF, 8'h55, 8'hAA})) o.status = ST_TYPE;
                     else if (dir > 1) o.status = ST_DIR;
                     else if (len != PAYLOAD_BYTES) o.status = ST_LENGTH;
                     else o.status = ST_OK;
                     if (o.status == ST_OK) begin
                        dl_store[p]      = rx_store[p];
                        has_good[p]      = 1'b1;
                        o.frame_id       = hdr_fields[p][7:0];
                        o.frame_type     = ty;
                        o.direction      = dir[0];
                        o.checksum_value = b;
                        n_good[p]++;
                     end else begin
                        n_badf[p]++;
                        n_badb[p] += FRAME_BYTES;
                     end
                     ppm[p]   = error_ppm(n_badb[p], n_bytes[p]);
                     phase[p] = PH_HUNT1;
                  end
               end
               default: phase[p] = PH_HUNT1;
            endcase
         end
         OP_CLEAR: begin
            n_bytes[p] = '0;
            n_good[p]  = '0;
            n_badf[p]  = '0;
            n_badb[p]  = '0;
            n_drop[p]  = '0;
            ppm[p]     = '0;
            phase[p]   = PH_HUNT1;
         end
         OP_READ: o.payload_byte = dl_store[p][r.payload_index];
         default: ;
      endcase
      o.rx_byte_cnt    = n_bytes[p];
      o.good_frame_cnt = n_good[p];
      o.bad_frame_cnt  = n_badf[p];
      o.bad_byte_cnt   = n_badb[p];
      o.drop_byte_cnt  = n_drop[p];
      o.err_ppm        = ppm[p];
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset, idle gaps
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------
   // Receiver: random pop gaps plus one long hold on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int seen;
      int gap;
      seen = 0;
      pop  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seq != seen) begin
            seen = hold_seq;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            pop <= 1'b1;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               pop <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            pop <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result check against the oldest expectation
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $error("%s: expected %0h, got %0h", name, e, a);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && pop && !empty) begin
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected");
            fails++;
         end else begin
            e = expected_q.pop_front();
            check_field("status",         e.status,         rsp_data.status);
            check_field("frame_id",       e.frame_id,       rsp_data.frame_id);
            check_field("frame_type",     e.frame_type,     rsp_data.frame_type);
            check_field("direction",      e.direction,      rsp_data.direction);
            check_field("checksum_value", e.checksum_value, rsp_data.checksum_value);
            check_field("payload_byte",   e.payload_byte,   rsp_data.payload_byte);
            check_field("rx_byte_cnt",    e.rx_byte_cnt,    rsp_data.rx_byte_cnt);
            check_field("good_frame_cnt", e.good_frame_cnt, rsp_data.good_frame_cnt);
            check_field("bad_frame_cnt",  e.bad_frame_cnt,  rsp_data.bad_frame_cnt);
            check_field("bad_byte_cnt",   e.bad_byte_cnt,   rsp_data.bad_byte_cnt);
            check_field("drop_byte_cnt",  e.drop_byte_cnt,  rsp_data.drop_byte_cnt);
            check_field("err_ppm",        e.err_ppm,        rsp_data.err_ppm);
         end
      end
   end

   // Watchdog: any beat on either side resets the count.
   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) idle = 0;
         else idle++;
         if (idle >= STALL_LIMIT) begin
            $display("serial_frame_receiver_with_stats: mismatch");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   // Called at a falling edge; returns at a falling edge. The prediction is
   // taken at the accepting edge. A typed expectation replaces it when given.
   task automatic send_beat(req_type r, bit typed = 1'b0, rsp_type typed_rsp = '0);
      rsp_type pred;
      int      gap;
      push     <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      pred = predict_rsp(r);
      expected_q.push_back(typed ? typed_rsp : pred);
      items_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_rx(logic [1:0] port, logic [7:0] b);
      req_type r;
      r = '{opcode: OP_RX, port: port, rx_byte: b, payload_index: 7'($urandom)};
      send_beat(r);
   endtask

   // Sends the first n_send bytes of a frame whose outcome is 'kind'.
   task automatic send_frame(logic [1:0] port, logic [2:0] kind, int n_send = FRAME_LEN);
      logic [7:0] fb[FRAME_LEN];
      logic [7:0] s;
      int         k;
      fb[0] = hdr_first;
      fb[1] = hdr_second;
      fb[2] = 8'($urandom);
      case ($urandom_range(0, 3))
         0: fb[3] = 8'h00;
         1: fb[3] = 8'hFF;
         2: fb[3] = 8'h55;
         default: fb[3] = 8'hAA;
      endcase
      fb[4] = 8'($urandom_range(0, 1));
      fb[5] = 8'(PAYLOAD_BYTES);
      if (kind == ST_TYPE) begin
         do fb[3] = 8'($urandom); while (fb[3] inside {8'h00, 8'hFF, 8'h55, 8'hAA});
      end
      if (kind == ST_DIR) fb[4] = 8'($urandom_range(2, 255));
      if (kind == ST_LENGTH) begin
         do fb[5] = 8'($urandom); while (fb[5] == PAYLOAD_BYTES);
      end
      for (k = 6; k < FRAME_LEN - 1; k++) fb[k] = 8'($urandom);
      s = '0;
      for (k = 2; k < FRAME_LEN - 1; k++) s += fb[k];
      fb[FRAME_LEN-1] = (kind == ST_CSUM) ? s + 8'($urandom_range(1, 255)) : s;
      for (k = 0; k < n_send; k++) send_rx(port, fb[k]);
   endtask

   task automatic send_noise();
      req_type r;
      int      c;
      r.port          = 2'($urandom);
      r.rx_byte       = 8'($urandom);
      r.payload_index = 7'($urandom);
      c = $urandom_range(0, 99);
      if (c < 30) begin
         r.opcode  = OP_RX;
         r.rx_byte = ($urandom_range(0, 1) == 1) ? hdr_first : hdr_second;
      end else if (c < 60) r.opcode = OP_RX;
      else if (c < 64) r.opcode = OP_CLEAR;
      else if (c < 90) r.opcode = has_good[r.port] ? OP_READ : OP_RX;
      else r.opcode = OP_NONE;  // unused opcode: counters only
      send_beat(r);
   endtask

   // Sender pause: wait for every expected beat, end on a falling edge.
   task automatic wait_drained();
      push <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
      @(negedge clock);
   endtask

   // Only while idle. Both header bytes written back to back.
   task automatic set_headers(logic [7:0] h1, logic [7:0] h2);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HDR1;
      csr_data  <= h1;
      @(negedge clock);
      csr_index <= CSR_HDR2;
      csr_data  <= h2;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      hdr_first  = h1;
      hdr_second = h2;
   endtask

   // ------------------------------------------------------------------
   // Directed rows; typed expectations only where obvious
   // ------------------------------------------------------------------
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row;

   stim_row steps[$];

   function automatic void add_row(logic [1:0] op, logic [1:0] port, logic [7:0] b,
                                   logic [6:0] idx, bit typed = 1'b0,
                                   rsp_type rsp = '0);
      stim_row s;
      s.req   = '{opcode: op, port: port, rx_byte: b, payload_index: idx};
      s.typed = typed;
      s.rsp   = rsp;
      steps.push_back(s);
   endfunction

   initial begin : stimulus
      rsp_type one_drop;
      logic [7:0] hdr_list[5][2];
      int  ph;
      int  c;
      int  quota;
      logic [1:0] fp;

      reset      = 1'b1;
      push       = 1'b0;
      req_data   = '0;
      csr_wr_en  = 1'b0;
      csr_index  = 1'b0;
      csr_data   = '0;
      fails      = 0;
      items_sent = 0;
      quiet      = 1'b0;
      hold_seq   = 0;
      hdr_first  = 8'hEB;
      hdr_second = 8'h90;
      for (int p = 0; p < PORT_COUNT; p++) begin
         phase[p]      = PH_HUNT1;
         body_pos[p]   = '0;
         body_sum[p]   = '0;
         hdr_fields[p] = '0;
         has_good[p]   = 1'b0;
         n_bytes[p]    = '0;
         n_good[p]     = '0;
         n_badf[p]     = '0;
         n_badb[p]     = '0;
         n_drop[p]     = '0;
         ppm[p]        = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_headers(8'hEB, 8'h90);

      // first byte off-header on a fresh port: one sync drop, full-scale rate
      one_drop               = '0;
      one_drop.rx_byte_cnt   = 32'd1;
      one_drop.bad_byte_cnt  = 32'd1;
      one_drop.drop_byte_cnt = 32'd1;
      one_drop.err_ppm       = 20'd1000000;

      add_row(OP_NONE,  2'd0, 8'hFF, 7'h7F, 1'b1, '0);  // unused opcode after reset
      add_row(OP_RX,    2'd1, 8'h00, 7'h00, 1'b1, one_drop);
      add_row(OP_RX,    2'd1, 8'hEB, 7'h00);
      add_row(OP_RX,    2'd1, 8'hEB, 7'h00);  // repeated first header byte
      add_row(OP_RX,    2'd1, 8'h90, 7'h00);  // into the body
      add_row(OP_CLEAR, 2'd1, 8'hFF, 7'h7F, 1'b1, '0);  // clear mid-frame
      add_row(OP_RX,    2'd2, 8'hEB, 7'h00);
      add_row(OP_RX,    2'd2, 8'hFF, 7'h00);  // wrong second byte, back to hunt
      add_row(OP_NONE,  2'd3, 8'h00, 7'h00);
      add_row(OP_CLEAR, 2'd0, 8'h00, 7'h00);
      foreach (steps[i]) send_beat(steps[i].req, steps[i].typed, steps[i].rsp);

      // one frame per outcome, then reads at both ends of the payload
      quiet = 1'b1;
      send_frame(2'd0, ST_OK);
      send_frame(2'd0, ST_CSUM);
      send_frame(2'd1, ST_TYPE);
      send_frame(2'd2, ST_DIR);
      send_frame(2'd3, ST_LENGTH);
      quiet = 1'b0;
      send_frame(2'd3, ST_OK);
      send_beat(req_type'{opcode: OP_READ, port: 2'd0, rx_byte: 8'h00,
                          payload_index: 7'h00});
      send_beat(req_type'{opcode: OP_READ, port: 2'd3, rx_byte: 8'hFF,
                          payload_index: 7'h7F});
      wait_drained();

      // header settings, extremes and equal bytes among them
      hdr_list = '{'{8'hEB, 8'h90}, '{8'h00, 8'hFF}, '{8'hFF, 8'h00},
                   '{8'hA5, 8'hA5}, '{8'h00, 8'h00}};
      hdr_list[4][0] = 8'($urandom);
      hdr_list[4][1] = 8'($urandom);
      for (ph = 0; ph < 5; ph++) begin
         set_headers(hdr_list[ph][0], hdr_list[ph][1]);
         quota = items_sent + (TARGET_ITEMS - items_sent) / (5 - ph);
         quiet = (ph == 2);
         if (ph == 1) begin
            // long receiver hold while the sender keeps offering beats
            hold_seq++;
            repeat (30) send_noise();
         end
         while (items_sent < quota) begin
            c  = $urandom_range(0, 99);
            fp = 2'($urandom);
            if (c < 25) send_frame(fp, ST_OK);
            else if (c < 40) send_frame(fp, 3'($urandom_range(ST_CSUM, ST_LENGTH)));
            else if (c < 48) begin
               // broken frame; often followed by a clear to resync the port
               send_frame(fp, ST_OK, $urandom_range(1, FRAME_LEN - 1));
               if ($urandom_range(0, 1) == 1)
                  send_beat(req_type'{opcode: OP_CLEAR, port: fp,
                                      rx_byte: 8'($urandom),
                                      payload_index: 7'($urandom)});
            end else repeat ($urandom_range(1, 8)) send_noise();
         end
         wait_drained();
      end

      repeat (200) @(posedge clock);
      if (fails == 0) $display("serial_frame_receiver_with_stats: match");
      else $display("serial_frame_receiver_with_stats: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
